@@ rtl/ihq_pkg.sv @@
package ihq_pkg;

  localparam int CAPACITY = 128;
  localparam int VALUE_W  = 32;
  localparam int NODES    = (CAPACITY + 1) / 2;
  localparam int NODE_W   = $clog2(NODES);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic [NODE_W-1:0]         node_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_REM_MIN = 2'd1,
    K_REM_MAX = 2'd2,
    K_REPLACE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_DMIN,
    PEND_DMAX
  } pend_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_INS_ODD,
    S_LONE,
    S_UPMIN,
    S_UPMIN_CMP,
    S_UPMAX,
    S_UPMAX_CMP,
    S_UPEND,
    S_DN_RD,
    S_DN_SWAP,
    S_DN_C1,
    S_DN_C2,
    S_REM0,
    S_REM1,
    S_SCAN,
    S_REPL,
    S_DONE
  } state_t;

  typedef struct packed {
    node_t ra;
    logic  lo_we;
    node_t lo_wa;
    val_t  lo_wd;
    logic  hi_we;
    node_t hi_wa;
    val_t  hi_wd;
  } mem_req_t;

  typedef struct packed {
    val_t lo;
    val_t hi;
  } mem_rsp_t;

  function automatic node_t parent(node_t i);
    node_t d;
    d = i - node_t'(1);
    return d >> 1;
  endfunction

endpackage

@@ rtl/ihq_mem.sv @@
module ihq_mem (
  input  logic              clk,
  input  ihq_pkg::mem_req_t req,
  output ihq_pkg::mem_rsp_t rsp
);

  ihq_pkg::val_t lo_mem [ihq_pkg::NODES];
  ihq_pkg::val_t hi_mem [ihq_pkg::NODES];
  ihq_pkg::val_t rd_lo_r;
  ihq_pkg::val_t rd_hi_r;

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (req.lo_we) begin
      lo_mem[req.lo_wa] <= req.lo_wd;
    end
    if (req.hi_we) begin
      hi_mem[req.hi_wa] <= req.hi_wd;
    end
    rd_lo_r <= (req.lo_we && req.lo_wa == req.ra) ? req.lo_wd : lo_mem[req.ra];
    rd_hi_r <= (req.hi_we && req.hi_wa == req.ra) ? req.hi_wd : hi_mem[req.ra];
  end

  assign rsp.lo = rd_lo_r;
  assign rsp.hi = rd_hi_r;

endmodule

@@ rtl/interval_heap_queue.sv @@
// One request is in work at a time; every heap step waits on the single
// registered read port of the node memory. A finished result waits in an output
// register while the next request is taken. Reset (rst_n low, synchronous) empties
// the queue; the node memories are not cleared.
module interval_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_replacement,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_removed_value,
  output logic [7:0]  out_held_count
);

  ihq_pkg::state_t  st_r, st_nxt;
  ihq_pkg::kind_t   kind_r, kind_nxt;
  ihq_pkg::cnt_t    n_r, n_nxt, cnt_r, cnt_nxt, sn_r, sn_nxt, sa_r, sa_nxt;
  ihq_pkg::val_t    x_r, x_nxt, r_r, r_nxt, pend_x_r, pend_x_nxt;
  ihq_pkg::val_t    c0lo_r, c0lo_nxt, c0hi_r, c0hi_nxt, got_r, got_nxt;
  ihq_pkg::val_t    lo_h_r, lo_h_nxt, hi_l_r, hi_l_nxt;
  ihq_pkg::node_t   idx_r, idx_nxt, base_r, base_nxt, dix_r, dix_nxt;
  ihq_pkg::node_t   lo_i_r, lo_i_nxt, hi_i_r, hi_i_nxt;
  ihq_pkg::pend_t   pend_r, pend_nxt;
  ihq_pkg::status_t status_r, status_nxt;
  logic             dn_max_r, dn_max_nxt, dv_r, dv_nxt;
  logic             flo_r, flo_nxt, fhi_r, fhi_nxt;

  logic             out_valid_r;
  ihq_pkg::status_t out_status_r;
  ihq_pkg::val_t    out_removed_r;
  ihq_pkg::cnt_t    out_count_r;

  ihq_pkg::mem_req_t req;
  ihq_pkg::mem_rsp_t rsp;
  ihq_pkg::val_t     rd_lo, rd_hi;

  ihq_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign rd_lo = rsp.lo;
  assign rd_hi = rsp.hi;

  // Shared decision terms.
  ihq_pkg::cnt_t  nlo, nfull, c_w, c1_w;
  ihq_pkg::node_t c_n, c1_n, best_n, par_n, k_n, last_n;
  ihq_pkg::val_t  v0, v1, bv, dn_x;
  logic has_c, has_c1, idx_full, dn_swap, pick1, dn_stop, best_full;
  logic scan_issue, scan_end, repl_lone, n_odd, is_max, done_load;

  assign nlo      = (sn_r + ihq_pkg::cnt_t'(1)) >> 1;
  assign nfull    = sn_r >> 1;
  assign c_w      = ihq_pkg::cnt_t'({idx_r, 1'b1});
  assign c1_w     = c_w + ihq_pkg::cnt_t'(1);
  assign c_n      = c_w[ihq_pkg::NODE_W-1:0];
  assign c1_n     = c1_w[ihq_pkg::NODE_W-1:0];
  assign has_c    = c_w < nlo;
  assign has_c1   = c1_w < nlo;
  assign idx_full = ihq_pkg::cnt_t'(idx_r) < nfull;
  assign par_n    = ihq_pkg::parent(idx_r);
  assign n_odd    = n_r[0];
  assign k_n      = n_r[ihq_pkg::NODE_W:1];
  assign last_n   = k_n - ihq_pkg::node_t'(1);
  assign is_max   = (kind_r == ihq_pkg::K_REM_MAX);

  assign dn_swap = dn_max_r ? (x_r < rd_lo) : (idx_full && x_r > rd_hi);
  assign dn_x    = dn_swap ? (dn_max_r ? rd_lo : rd_hi) : x_r;
  // For a max sift a child that is not full offers its lone value.
  assign v0      = (dn_max_r && c_w < nfull) ? c0hi_r : c0lo_r;
  assign v1      = (dn_max_r && c1_w < nfull) ? rd_hi : rd_lo;
  assign pick1   = has_c1 && (dn_max_r ? (v1 > v0) : (v1 < v0));
  assign bv      = pick1 ? v1 : v0;
  assign best_n  = pick1 ? c1_n : c_n;
  assign dn_stop = dn_max_r ? (bv <= x_r) : (bv >= x_r);
  assign best_full = ihq_pkg::cnt_t'(best_n) < nfull;

  assign scan_issue = sa_r < nlo;
  assign scan_end   = !scan_issue && !dv_r;
  assign repl_lone  = ihq_pkg::cnt_t'(lo_i_r) >= nfull;
  assign done_load  = (st_r == ihq_pkg::S_DONE) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ihq_pkg::S_IDLE: begin
        if (in_valid) st_nxt = ihq_pkg::S_DISP;
      end
      ihq_pkg::S_DISP: begin
        case (kind_r)
          ihq_pkg::K_INSERT: begin
            if (n_r == ihq_pkg::cnt_t'(ihq_pkg::CAPACITY)) st_nxt = ihq_pkg::S_DONE;
            else if (n_odd) st_nxt = ihq_pkg::S_INS_ODD;
            else if (k_n == '0) st_nxt = ihq_pkg::S_DONE;
            else st_nxt = ihq_pkg::S_LONE;
          end
          ihq_pkg::K_REPLACE: begin
            st_nxt = (n_r == '0) ? ihq_pkg::S_DONE : ihq_pkg::S_SCAN;
          end
          default: begin
            st_nxt = (n_r == '0) ? ihq_pkg::S_DONE : ihq_pkg::S_REM0;
          end
        endcase
      end
      ihq_pkg::S_INS_ODD: begin
        st_nxt = (x_r < rd_lo) ? ihq_pkg::S_UPMIN : ihq_pkg::S_UPMAX;
      end
      ihq_pkg::S_LONE: begin
        if (x_r < rd_lo) st_nxt = ihq_pkg::S_UPMIN;
        else if (x_r > rd_hi) st_nxt = ihq_pkg::S_UPMAX;
        else st_nxt = ihq_pkg::S_UPEND;
      end
      ihq_pkg::S_UPMIN: begin
        st_nxt = (idx_r == '0) ? ihq_pkg::S_UPEND : ihq_pkg::S_UPMIN_CMP;
      end
      ihq_pkg::S_UPMIN_CMP: begin
        st_nxt = (x_r >= rd_lo) ? ihq_pkg::S_UPEND : ihq_pkg::S_UPMIN;
      end
      ihq_pkg::S_UPMAX: begin
        st_nxt = (idx_r == '0) ? ihq_pkg::S_UPEND : ihq_pkg::S_UPMAX_CMP;
      end
      ihq_pkg::S_UPMAX_CMP: begin
        st_nxt = (x_r <= rd_hi) ? ihq_pkg::S_UPEND : ihq_pkg::S_UPMAX;
      end
      ihq_pkg::S_UPEND: begin
        st_nxt = (pend_r != ihq_pkg::PEND_NONE) ? ihq_pkg::S_DN_RD : ihq_pkg::S_DONE;
      end
      ihq_pkg::S_DN_RD: st_nxt = ihq_pkg::S_DN_SWAP;
      ihq_pkg::S_DN_SWAP: begin
        st_nxt = has_c ? ihq_pkg::S_DN_C1 : ihq_pkg::S_DONE;
      end
      ihq_pkg::S_DN_C1: st_nxt = ihq_pkg::S_DN_C2;
      ihq_pkg::S_DN_C2: begin
        if (dn_stop || (dn_max_r && !best_full)) st_nxt = ihq_pkg::S_DONE;
        else st_nxt = ihq_pkg::S_DN_RD;
      end
      ihq_pkg::S_REM0: begin
        st_nxt = (n_r <= ihq_pkg::cnt_t'(2)) ? ihq_pkg::S_DONE : ihq_pkg::S_REM1;
      end
      ihq_pkg::S_REM1: st_nxt = ihq_pkg::S_DN_RD;
      ihq_pkg::S_SCAN: begin
        if (scan_end) st_nxt = ihq_pkg::S_REPL;
      end
      ihq_pkg::S_REPL: begin
        if (flo_r) begin
          if (repl_lone) st_nxt = (lo_i_r == '0) ? ihq_pkg::S_DONE : ihq_pkg::S_LONE;
          else if (r_r > lo_h_r) st_nxt = ihq_pkg::S_UPMAX;
          else if (r_r < x_r) st_nxt = ihq_pkg::S_UPMIN;
          else st_nxt = ihq_pkg::S_DN_RD;
        end else if (fhi_r) begin
          if (r_r < hi_l_r) st_nxt = ihq_pkg::S_UPMIN;
          else if (r_r > x_r) st_nxt = ihq_pkg::S_UPMAX;
          else st_nxt = ihq_pkg::S_DN_RD;
        end else begin
          st_nxt = ihq_pkg::S_DONE;
        end
      end
      ihq_pkg::S_DONE: begin
        if (done_load) st_nxt = ihq_pkg::S_IDLE;
      end
      default: st_nxt = ihq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    kind_nxt   = kind_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    sn_nxt     = sn_r;
    sa_nxt     = sa_r;
    x_nxt      = x_r;
    r_nxt      = r_r;
    pend_x_nxt = pend_x_r;
    c0lo_nxt   = c0lo_r;
    c0hi_nxt   = c0hi_r;
    got_nxt    = got_r;
    lo_h_nxt   = lo_h_r;
    hi_l_nxt   = hi_l_r;
    idx_nxt    = idx_r;
    base_nxt   = base_r;
    dix_nxt    = dix_r;
    lo_i_nxt   = lo_i_r;
    hi_i_nxt   = hi_i_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    dn_max_nxt = dn_max_r;
    dv_nxt     = 1'b0;
    flo_nxt    = flo_r;
    fhi_nxt    = fhi_r;
    req        = '0;
    case (st_r)
      ihq_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = ihq_pkg::kind_t'(in_kind);
          x_nxt      = in_value;
          r_nxt      = in_replacement;
          n_nxt      = cnt_r;
          status_nxt = ihq_pkg::ST_OK;
          got_nxt    = '0;
          pend_nxt   = ihq_pkg::PEND_NONE;
        end
      end
      ihq_pkg::S_DISP: begin
        case (kind_r)
          ihq_pkg::K_INSERT: begin
            if (n_r == ihq_pkg::cnt_t'(ihq_pkg::CAPACITY)) begin
              status_nxt = ihq_pkg::ST_FULL;
            end else begin
              cnt_nxt = n_r + ihq_pkg::cnt_t'(1);
              idx_nxt = k_n;
              if (n_odd) begin
                req.ra = k_n;
              end else if (k_n == '0) begin
                req.lo_we = 1'b1;
                req.lo_wa = '0;
                req.lo_wd = x_r;
              end else begin
                req.ra = ihq_pkg::parent(k_n);
              end
            end
          end
          ihq_pkg::K_REPLACE: begin
            if (n_r == '0) begin
              status_nxt = ihq_pkg::ST_NOTFOUND;
            end else begin
              sn_nxt  = n_r;
              sa_nxt  = '0;
              flo_nxt = 1'b0;
              fhi_nxt = 1'b0;
            end
          end
          default: begin
            if (n_r == '0) status_nxt = ihq_pkg::ST_EMPTY;
            req.ra = '0;
          end
        endcase
      end
      ihq_pkg::S_INS_ODD: begin
        if (x_r < rd_lo) begin
          req.hi_we = 1'b1;
          req.hi_wa = idx_r;
          req.hi_wd = rd_lo;
        end
      end
      ihq_pkg::S_LONE: begin
        if (x_r < rd_lo) begin
          idx_nxt = idx_r;
        end else if (x_r > rd_hi) begin
          // The parent's high end drops into the lone slot.
          req.lo_we = 1'b1;
          req.lo_wa = idx_r;
          req.lo_wd = rd_hi;
          idx_nxt   = par_n;
        end else begin
          req.lo_we = 1'b1;
          req.lo_wa = idx_r;
          req.lo_wd = x_r;
        end
      end
      ihq_pkg::S_UPMIN: begin
        if (idx_r == '0) begin
          req.lo_we = 1'b1;
          req.lo_wa = '0;
          req.lo_wd = x_r;
        end else begin
          req.ra = par_n;
        end
      end
      ihq_pkg::S_UPMIN_CMP: begin
        req.lo_we = 1'b1;
        req.lo_wa = idx_r;
        if (x_r >= rd_lo) begin
          req.lo_wd = x_r;
        end else begin
          req.lo_wd = rd_lo;
          idx_nxt   = par_n;
        end
      end
      ihq_pkg::S_UPMAX: begin
        if (idx_r == '0) begin
          req.hi_we = 1'b1;
          req.hi_wa = '0;
          req.hi_wd = x_r;
        end else begin
          req.ra = par_n;
        end
      end
      ihq_pkg::S_UPMAX_CMP: begin
        req.hi_we = 1'b1;
        req.hi_wa = idx_r;
        if (x_r <= rd_hi) begin
          req.hi_wd = x_r;
        end else begin
          req.hi_wd = rd_hi;
          idx_nxt   = par_n;
        end
      end
      ihq_pkg::S_UPEND: begin
        if (pend_r != ihq_pkg::PEND_NONE) begin
          idx_nxt    = base_r;
          x_nxt      = pend_x_r;
          sn_nxt     = cnt_r;
          dn_max_nxt = (pend_r == ihq_pkg::PEND_DMAX);
          pend_nxt   = ihq_pkg::PEND_NONE;
        end
      end
      ihq_pkg::S_DN_RD: begin
        req.ra = idx_r;
      end
      ihq_pkg::S_DN_SWAP: begin
        x_nxt = dn_x;
        if (dn_swap) begin
          if (dn_max_r) begin
            req.lo_we = 1'b1;
            req.lo_wa = idx_r;
            req.lo_wd = x_r;
          end else begin
            req.hi_we = 1'b1;
            req.hi_wa = idx_r;
            req.hi_wd = x_r;
          end
        end
        if (!has_c) begin
          if (dn_max_r) begin
            req.hi_we = 1'b1;
            req.hi_wa = idx_r;
            req.hi_wd = dn_x;
          end else begin
            req.lo_we = 1'b1;
            req.lo_wa = idx_r;
            req.lo_wd = dn_x;
          end
        end else begin
          req.ra = c_n;
        end
      end
      ihq_pkg::S_DN_C1: begin
        c0lo_nxt = rd_lo;
        c0hi_nxt = rd_hi;
        req.ra   = c1_n;
      end
      ihq_pkg::S_DN_C2: begin
        if (dn_max_r) begin
          req.hi_we = 1'b1;
          req.hi_wa = idx_r;
          req.hi_wd = dn_stop ? x_r : bv;
          if (!dn_stop && !best_full) begin
            req.lo_we = 1'b1;
            req.lo_wa = best_n;
            req.lo_wd = x_r;
          end
        end else begin
          req.lo_we = 1'b1;
          req.lo_wa = idx_r;
          req.lo_wd = dn_stop ? x_r : bv;
        end
        if (!dn_stop) idx_nxt = best_n;
      end
      ihq_pkg::S_REM0: begin
        if (n_r == ihq_pkg::cnt_t'(1)) begin
          got_nxt = rd_lo;
        end else begin
          got_nxt = is_max ? rd_hi : rd_lo;
        end
        cnt_nxt = n_r - ihq_pkg::cnt_t'(1);
        if (n_r == ihq_pkg::cnt_t'(2)) begin
          if (!is_max) begin
            req.lo_we = 1'b1;
            req.lo_wa = '0;
            req.lo_wd = rd_hi;
          end
        end else begin
          req.ra = n_odd ? k_n : last_n;
        end
      end
      ihq_pkg::S_REM1: begin
        if (!n_odd && is_max) begin
          x_nxt = rd_hi;
        end else begin
          x_nxt = rd_lo;
        end
        if (!n_odd && !is_max) begin
          req.lo_we = 1'b1;
          req.lo_wa = last_n;
          req.lo_wd = rd_hi;
        end
        idx_nxt    = '0;
        sn_nxt     = cnt_r;
        dn_max_nxt = is_max;
      end
      ihq_pkg::S_SCAN: begin
        req.ra  = sa_r[ihq_pkg::NODE_W-1:0];
        dv_nxt  = scan_issue;
        dix_nxt = sa_r[ihq_pkg::NODE_W-1:0];
        if (scan_issue) sa_nxt = sa_r + ihq_pkg::cnt_t'(1);
        if (dv_r) begin
          if (!flo_r && rd_lo == x_r) begin
            flo_nxt  = 1'b1;
            lo_i_nxt = dix_r;
            lo_h_nxt = rd_hi;
          end
          if (!fhi_r && ihq_pkg::cnt_t'(dix_r) < nfull && rd_hi == x_r) begin
            fhi_nxt  = 1'b1;
            hi_i_nxt = dix_r;
            hi_l_nxt = rd_lo;
          end
        end
      end
      ihq_pkg::S_REPL: begin
        x_nxt  = r_r;
        sn_nxt = n_r;
        if (flo_r) begin
          idx_nxt = lo_i_r;
          if (repl_lone) begin
            if (lo_i_r == '0) begin
              req.lo_we = 1'b1;
              req.lo_wa = '0;
              req.lo_wd = r_r;
            end else begin
              req.ra = ihq_pkg::parent(lo_i_r);
            end
          end else if (r_r > lo_h_r) begin
            // New value climbs the max side; the old high end sinks from here.
            pend_nxt   = ihq_pkg::PEND_DMIN;
            pend_x_nxt = lo_h_r;
            base_nxt   = lo_i_r;
          end
          dn_max_nxt = 1'b0;
        end else if (fhi_r) begin
          idx_nxt = hi_i_r;
          if (r_r < hi_l_r) begin
            pend_nxt   = ihq_pkg::PEND_DMAX;
            pend_x_nxt = hi_l_r;
            base_nxt   = hi_i_r;
          end
          dn_max_nxt = 1'b1;
        end else begin
          status_nxt = ihq_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ihq_pkg::S_IDLE;
      cnt_r    <= '0;
      pend_r   <= ihq_pkg::PEND_NONE;
      dv_r     <= 1'b0;
      flo_r    <= 1'b0;
      fhi_r    <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      dv_r     <= dv_nxt;
      flo_r    <= flo_nxt;
      fhi_r    <= fhi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    n_r      <= n_nxt;
    sn_r     <= sn_nxt;
    sa_r     <= sa_nxt;
    x_r      <= x_nxt;
    r_r      <= r_nxt;
    pend_x_r <= pend_x_nxt;
    c0lo_r   <= c0lo_nxt;
    c0hi_r   <= c0hi_nxt;
    got_r    <= got_nxt;
    lo_h_r   <= lo_h_nxt;
    hi_l_r   <= hi_l_nxt;
    idx_r    <= idx_nxt;
    base_r   <= base_nxt;
    dix_r    <= dix_nxt;
    lo_i_r   <= lo_i_nxt;
    hi_i_r   <= hi_i_nxt;
    status_r <= status_nxt;
    dn_max_r <= dn_max_nxt;
  end

  // Output register: loaded when a request finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_status_r  <= status_r;
      out_removed_r <= (status_r == ihq_pkg::ST_OK) ? got_r : '0;
      out_count_r   <= cnt_r;
    end
  end

  assign in_ready          = (st_r == ihq_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_held_count    = out_count_r;

endmodule

@@ rtl/ihq_checker.sv @@
module ihq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic signed [31:0] out_removed_value,
  input logic [7:0]  out_held_count
);

  // The count can never go past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_held_count <= 8'(ihq_pkg::CAPACITY))
    else $error("held count beyond capacity");

  // A rejected insert is only reported when the queue is full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ihq_pkg::ST_FULL) |->
      out_held_count == 8'(ihq_pkg::CAPACITY))
    else $error("full status with room left");

  // A remove from an empty queue returns zero and leaves it empty.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ihq_pkg::ST_EMPTY) |->
      (out_held_count == 8'd0 && out_removed_value == 32'sd0))
    else $error("empty status inconsistent");

  // A waiting result transaction holds its status and held count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_held_count)))
    else $error("result changed while stalled");

  // Once a request transaction is taken, the input closes while it is worked on.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again without a busy cycle");

endmodule

bind interval_heap_queue ihq_checker u_ihq_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    ihq_pkg::status_t status;
    ihq_pkg::val_t    removed;
    int               count;
  } heap_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_kind;
  logic signed [31:0] in_value;
  logic signed [31:0] in_replacement;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic signed [31:0] out_removed_value;
  logic [7:0] out_held_count;

  heap_result_t pending_results[$];
  int errors;
  int cycles;
  int checked;
  int sent;
  int long_hold_req;

  // Shadow interval heap used to predict every result.
  ihq_pkg::val_t lo_end[ihq_pkg::NODES];
  ihq_pkg::val_t hi_end[ihq_pkg::NODES];
  int held;

  interval_heap_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_value(in_value), .in_replacement(in_replacement),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_removed_value(out_removed_value),
    .out_held_count(out_held_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void sift_up_low(int i, ihq_pkg::val_t x);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (x >= lo_end[p]) break;
      lo_end[i] = lo_end[p];
      i = p;
    end
    lo_end[i] = x;
  endfunction

  function automatic void sift_up_high(int i, ihq_pkg::val_t x);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (x <= hi_end[p]) break;
      hi_end[i] = hi_end[p];
      i = p;
    end
    hi_end[i] = x;
  endfunction

  function automatic void sift_down_low(int i, ihq_pkg::val_t x, int n);
    int nlo;
    int nfull;
    int c;
    int best;
    ihq_pkg::val_t t;
    nlo = (n + 1) / 2;
    nfull = n / 2;
    while (1) begin
      if (i < nfull && x > hi_end[i]) begin
        t = hi_end[i];
        hi_end[i] = x;
        x = t;
      end
      c = 2 * i + 1;
      if (c >= nlo) break;
      best = c;
      if (c + 1 < nlo && lo_end[c + 1] < lo_end[c]) best = c + 1;
      if (lo_end[best] >= x) break;
      lo_end[i] = lo_end[best];
      i = best;
    end
    lo_end[i] = x;
  endfunction

  function automatic void sift_down_high(int i, ihq_pkg::val_t x, int n);
    int nlo;
    int nfull;
    int c;
    int best;
    ihq_pkg::val_t t;
    ihq_pkg::val_t bv;
    ihq_pkg::val_t cv;
    nlo = (n + 1) / 2;
    nfull = n / 2;
    while (1) begin
      if (x < lo_end[i]) begin
        t = lo_end[i];
        lo_end[i] = x;
        x = t;
      end
      c = 2 * i + 1;
      if (c >= nlo) break;
      best = c;
      bv = (c < nfull) ? hi_end[c] : lo_end[c];
      if (c + 1 < nlo) begin
        cv = (c + 1 < nfull) ? hi_end[c + 1] : lo_end[c + 1];
        if (cv > bv) begin
          best = c + 1;
          bv = cv;
        end
      end
      if (bv <= x) break;
      hi_end[i] = bv;
      if (best >= nfull) begin
        lo_end[best] = x;
        return;
      end
      i = best;
    end
    hi_end[i] = x;
  endfunction

  function automatic void place_single(int k, ihq_pkg::val_t x);
    int p;
    if (k == 0) begin
      lo_end[0] = x;
      return;
    end
    p = (k - 1) / 2;
    if (x < lo_end[p]) begin
      sift_up_low(k, x);
    end else if (x > hi_end[p]) begin
      lo_end[k] = hi_end[p];
      sift_up_high(p, x);
    end else begin
      lo_end[k] = x;
    end
  endfunction

  function automatic ihq_pkg::status_t heap_insert(ihq_pkg::val_t x);
    int k;
    ihq_pkg::val_t y;
    k = held / 2;
    if (held >= ihq_pkg::CAPACITY) return ihq_pkg::ST_FULL;
    if (held % 2 == 0) begin
      place_single(k, x);
    end else begin
      y = lo_end[k];
      if (x < y) begin
        hi_end[k] = y;
        sift_up_low(k, x);
      end else begin
        sift_up_high(k, x);
      end
    end
    held++;
    return ihq_pkg::ST_OK;
  endfunction

  function automatic ihq_pkg::status_t heap_remove(bit want_max, output ihq_pkg::val_t got);
    int n;
    int last;
    ihq_pkg::val_t x;
    n = held;
    got = '0;
    if (n == 0) return ihq_pkg::ST_EMPTY;
    if (n == 1) begin
      got = lo_end[0];
      held = 0;
      return ihq_pkg::ST_OK;
    end
    got = want_max ? hi_end[0] : lo_end[0];
    if (n == 2) begin
      if (!want_max) lo_end[0] = hi_end[0];
      held = 1;
      return ihq_pkg::ST_OK;
    end
    if (n % 2 == 1) begin
      x = lo_end[n / 2];
    end else begin
      last = n / 2 - 1;
      if (want_max) begin
        x = hi_end[last];
      end else begin
        x = lo_end[last];
        lo_end[last] = hi_end[last];
      end
    end
    held = n - 1;
    if (want_max) sift_down_high(0, x, n - 1);
    else sift_down_low(0, x, n - 1);
    return ihq_pkg::ST_OK;
  endfunction

  function automatic ihq_pkg::status_t heap_replace(ihq_pkg::val_t f, ihq_pkg::val_t r);
    int nlo;
    int nfull;
    ihq_pkg::val_t old;
    nlo = (held + 1) / 2;
    nfull = held / 2;
    for (int i = 0; i < nlo; i++) begin
      if (lo_end[i] != f) continue;
      if (i >= nfull) begin
        place_single(i, r);
      end else if (r > hi_end[i]) begin
        old = hi_end[i];
        sift_up_high(i, r);
        sift_down_low(i, old, held);
      end else if (r < f) begin
        sift_up_low(i, r);
      end else begin
        sift_down_low(i, r, held);
      end
      return ihq_pkg::ST_OK;
    end
    for (int i = 0; i < nfull; i++) begin
      if (hi_end[i] != f) continue;
      if (r < lo_end[i]) begin
        old = lo_end[i];
        sift_up_low(i, r);
        sift_down_high(i, old, held);
      end else if (r > f) begin
        sift_up_high(i, r);
      end else begin
        sift_down_high(i, r, held);
      end
      return ihq_pkg::ST_OK;
    end
    return ihq_pkg::ST_NOTFOUND;
  endfunction

  // Any value currently held; only called with a nonempty queue.
  function automatic ihq_pkg::val_t held_value();
    int idx;
    idx = $urandom_range(held - 1);
    if (idx < (held + 1) / 2) return lo_end[idx];
    return hi_end[idx - (held + 1) / 2];
  endfunction

  function automatic ihq_pkg::val_t random_value();
    case ($urandom_range(3))
      0: return ihq_pkg::val_t'($urandom);
      1: return ihq_pkg::val_t'($urandom_range(20)) - ihq_pkg::val_t'(10);
      2: return $urandom_range(1) ? ihq_pkg::val_t'(32'h7fffffff)
                                  : ihq_pkg::val_t'(32'h80000000);
      default: return ihq_pkg::val_t'($urandom_range(1000)) - ihq_pkg::val_t'(500);
    endcase
  endfunction

  task automatic send_request(ihq_pkg::kind_t kind, ihq_pkg::val_t value,
                              ihq_pkg::val_t repl);
    int gap;
    heap_result_t res;
    gap = $urandom_range(4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = kind;
    in_value = value;
    in_replacement = repl;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    res.removed = '0;
    case (kind)
      ihq_pkg::K_INSERT:  res.status = heap_insert(value);
      ihq_pkg::K_REM_MIN: res.status = heap_remove(1'b0, res.removed);
      ihq_pkg::K_REM_MAX: res.status = heap_remove(1'b1, res.removed);
      default:            res.status = heap_replace(value, repl);
    endcase
    res.count = held;
    pending_results.push_back(res);
    sent++;
    @(negedge clk);
  endtask

  task automatic test_empty_queue();
    send_request(ihq_pkg::K_REM_MIN, 0, 0);
    send_request(ihq_pkg::K_REM_MAX, 0, 0);
    send_request(ihq_pkg::K_REPLACE, 5, 6);
  endtask

  task automatic test_extremes_and_duplicates();
    send_request(ihq_pkg::K_INSERT, 32'sh7fffffff, 0);
    send_request(ihq_pkg::K_INSERT, 32'sh80000000, -1);
    send_request(ihq_pkg::K_INSERT, 0, 0);
    send_request(ihq_pkg::K_INSERT, -1, 0);
    send_request(ihq_pkg::K_INSERT, 7, 0);
    send_request(ihq_pkg::K_INSERT, 7, 0);
    send_request(ihq_pkg::K_REPLACE, 7, 7);
    send_request(ihq_pkg::K_REPLACE, 7, 32'sh80000000);
    send_request(ihq_pkg::K_REPLACE, 32'sh7fffffff, -2);
    send_request(ihq_pkg::K_REPLACE, 123, 4);
    send_request(ihq_pkg::K_REPLACE, -1, 32'sh7fffffff);
    send_request(ihq_pkg::K_REM_MAX, 0, 0);
    send_request(ihq_pkg::K_REM_MIN, 0, 0);
    send_request(ihq_pkg::K_REM_MIN, 0, 0);
    send_request(ihq_pkg::K_REM_MAX, 0, 0);
    send_request(ihq_pkg::K_REM_MIN, 0, 0);
    send_request(ihq_pkg::K_REM_MIN, 0, 0);
  endtask

  // Fill completely, overflow once, replace one held value, then drain from both ends.
  task automatic test_full_queue();
    while (held < ihq_pkg::CAPACITY) send_request(ihq_pkg::K_INSERT, random_value(), 0);
    send_request(ihq_pkg::K_INSERT, 1, 0);
    send_request(ihq_pkg::K_REPLACE, held_value(), random_value());
    while (held > 0) begin
      send_request($urandom_range(1) ? ihq_pkg::K_REM_MIN : ihq_pkg::K_REM_MAX, 0, 0);
    end
  endtask

  task automatic test_random_mix(int count, int target);
    int pick;
    ihq_pkg::val_t v;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40 + (held < target ? 20 : -20)) begin
        send_request(ihq_pkg::K_INSERT, random_value(), random_value());
      end else if (pick < 75) begin
        send_request(pick % 2 ? ihq_pkg::K_REM_MIN : ihq_pkg::K_REM_MAX,
                     random_value(), random_value());
      end else begin
        v = (held > 0 && pick < 92) ? held_value() : random_value();
        send_request(ihq_pkg::K_REPLACE, v, random_value());
      end
    end
  endtask

  // The receiver stalls for a long stretch while requests keep arriving.
  task automatic test_output_backpressure();
    long_hold_req = 1;
    test_random_mix(12, 40);
  endtask

  initial begin
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_ready = 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
      end
      hold = $urandom_range(4);
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    heap_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction status %0d removed %0d count %0d",
                 $time, out_status, out_removed_value, out_held_count);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        checked++;
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
          errors++;
        end
        if (out_removed_value !== exp_res.removed) begin
          $display("%0t: removed value expected %0d actual %0d",
                   $time, exp_res.removed, out_removed_value);
          errors++;
        end
        if (out_held_count !== 8'(exp_res.count)) begin
          $display("%0t: held count expected %0d actual %0d",
                   $time, exp_res.count, out_held_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    checked = 0;
    sent = 0;
    held = 0;
    long_hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = ihq_pkg::K_INSERT;
    in_value = '0;
    in_replacement = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_queue();
    test_extremes_and_duplicates();
    test_full_queue();
    test_output_backpressure();
    test_random_mix(100, 10);
    test_random_mix(140, 60);
    test_random_mix(70, 120);
    test_random_mix(50, 3);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d requests (insert, both removes, replace, full and empty cases),",
             sent);
    $display("checked %0d results with random idling and one long output stall.", checked);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
